// ===== rtl/edc_pkg.sv =====
// Shared types and constants of the external interrupt edge controller.
`timescale 1ns / 1ps

package edc_pkg;

  // Field widths fixed by the bus item layout.
  localparam int DATA_W    = 16;
  localparam int PIN_W     = 64;
  localparam int NIB_W     = 4;
  localparam int MAX_LINES = 16;
  localparam int SEL_WORDS = 4;

  // Request kinds.
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;

  // Register addresses.
  localparam logic [3:0] REG_INT_MASK = 4'd0;
  localparam logic [3:0] REG_EVT_MASK = 4'd1;
  localparam logic [3:0] REG_RISE_EN  = 4'd2;
  localparam logic [3:0] REG_FALL_EN  = 4'd3;
  localparam logic [3:0] REG_PENDING  = 4'd4;
  localparam logic [3:0] REG_SEL0     = 4'd5;
  localparam logic [3:0] REG_SEL1     = 4'd6;
  localparam logic [3:0] REG_SEL2     = 4'd7;
  localparam logic [3:0] REG_SEL3     = 4'd8;

  // Command broadcast from the input side to every lane and the merge stage.
  typedef struct packed {
    logic              valid;
    logic [1:0]        req;
    logic [3:0]        idx;
    logic [DATA_W-1:0] wdata;
    logic [PIN_W-1:0]  pins;
  } edc_cmd_t;

  // What one lane reports back for the current command.
  typedef struct packed {
    logic             rd_bit;
    logic [NIB_W-1:0] sel;
    logic             irq;
    logic             pulse;
  } edc_lane_stat_t;

endpackage

// ===== rtl/external_interrupt_edge_controller.sv =====
// Top level of the external interrupt edge controller: lanes, merge stage and handshake.
`timescale 1ns / 1ps

// The controller takes one transfer per clock and returns one result per transfer,
// in the cycle after it is accepted. Every line is its own lane that updates its
// registers and edge detector in the cycle of acceptance; the merge stage packs
// the lane reports into a single output register, and the input stays ready as
// long as that register is empty or is being taken in the same cycle. Pending
// bits are write-one-to-clear, a port number of PORTS or more feeds a low level,
// and lines at or above LINES read as zero everywhere.
module external_interrupt_edge_controller #(
  parameter int LINES = 16,
  parameter int PORTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] write_data, [79:16] pin_levels
  input  logic [79:0] in_tdata,
  // [1:0] req_type, [5:2] reg_index
  input  logic [5:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] read_data, [31:16] irq_lines, [47:32] event_pulse
  output logic [47:0] out_tdata
);

  edc_pkg::edc_cmd_t       cmd;
  edc_pkg::edc_lane_stat_t lane_stat [edc_pkg::MAX_LINES];
  logic                    in_accept;

  // Input is taken whenever the output register can be refilled.
  assign in_tready = ~out_tvalid | out_tready;
  assign in_accept = in_tvalid & in_tready;

  assign cmd.valid = in_accept;
  assign cmd.req   = in_tuser[1:0];
  assign cmd.idx   = in_tuser[5:2];
  assign cmd.wdata = in_tdata[15:0];
  assign cmd.pins  = in_tdata[79:16];

  // One lane per implemented line; the rest report zeros.
  for (genvar g = 0; g < edc_pkg::MAX_LINES; g++) begin : g_lane
    if (g < LINES) begin : g_on
      edc_lane #(
        .LINE  (g),
        .PORTS (PORTS)
      ) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (lane_stat[g])
      );
    end else begin : g_off
      assign lane_stat[g] = '0;
    end
  end

  edc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .lane_stat  (lane_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // An accepted transfer always leaves a result behind.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_tvalid)
    else $error("accepted transfer produced no result");

  // Input only stalls while a result waits.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output register");

  // Only sample transfers may pulse events.
  a_pulse_only_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser[1:0] != edc_pkg::REQ_SAMPLE) |=> out_tdata[47:32] == 16'd0)
    else $error("event pulse on a non-sample transfer");

  // Only read transfers return read data.
  a_read_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser[1:0] != edc_pkg::REQ_READ) |=> out_tdata[15:0] == 16'd0)
    else $error("read data on a non-read transfer");

  // Lines beyond the implemented count never request.
  a_no_irq_beyond_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:16] >> LINES) == 16'd0)
    else $error("interrupt request on an unimplemented line");

endmodule

// ===== rtl/edc_lane.sv =====
// One interrupt line: its register bits, source select, edge detect and pending flag.
`timescale 1ns / 1ps

module edc_lane #(
  parameter int LINE  = 0,
  parameter int PORTS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  edc_pkg::edc_cmd_t       cmd,
  output edc_pkg::edc_lane_stat_t stat
);

  localparam logic [3:0] SEL_ADDR = edc_pkg::REG_SEL0 + 4'(LINE / 4);
  localparam int         NIB_LSB  = 4 * (LINE % 4);
  localparam logic [3:0] LINE_BIT = 4'(LINE);
  localparam logic [3:0] PORT_LIM = 4'(PORTS);

  logic                      imask_r, imask_nxt;
  logic                      emask_r, emask_nxt;
  logic                      ren_r, ren_nxt;
  logic                      fen_r, fen_nxt;
  logic                      pend_r, pend_nxt;
  logic                      last_r, last_nxt;
  logic [edc_pkg::NIB_W-1:0] sel_r, sel_nxt;
  logic                      cur;
  logic                      trig;

  // Pin of the selected port; ports beyond the last one read low.
  always_comb begin
    if (sel_r < PORT_LIM) begin
      cur = cmd.pins[{sel_r[1:0], LINE_BIT}];
    end else begin
      cur = 1'b0;
    end
    trig = (cur & ~last_r & ren_r) | (~cur & last_r & fen_r);
  end

  // Next state for the current command.
  always_comb begin
    imask_nxt = imask_r;
    emask_nxt = emask_r;
    ren_nxt   = ren_r;
    fen_nxt   = fen_r;
    pend_nxt  = pend_r;
    last_nxt  = last_r;
    sel_nxt   = sel_r;
    case (cmd.req)
      edc_pkg::REQ_SAMPLE: begin
        pend_nxt = pend_r | trig;
        last_nxt = cur;
      end
      edc_pkg::REQ_WRITE: begin
        case (cmd.idx)
          edc_pkg::REG_INT_MASK: imask_nxt = cmd.wdata[LINE];
          edc_pkg::REG_EVT_MASK: emask_nxt = cmd.wdata[LINE];
          edc_pkg::REG_RISE_EN:  ren_nxt   = cmd.wdata[LINE];
          edc_pkg::REG_FALL_EN:  fen_nxt   = cmd.wdata[LINE];
          edc_pkg::REG_PENDING:  pend_nxt  = pend_r & ~cmd.wdata[LINE];
          default: begin
            if (cmd.idx == SEL_ADDR) begin
              sel_nxt = cmd.wdata[NIB_LSB +: edc_pkg::NIB_W];
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Read bit and result bits seen after this command.
  always_comb begin
    stat.rd_bit = 1'b0;
    case (cmd.idx)
      edc_pkg::REG_INT_MASK: stat.rd_bit = imask_r;
      edc_pkg::REG_EVT_MASK: stat.rd_bit = emask_r;
      edc_pkg::REG_RISE_EN:  stat.rd_bit = ren_r;
      edc_pkg::REG_FALL_EN:  stat.rd_bit = fen_r;
      edc_pkg::REG_PENDING:  stat.rd_bit = pend_r;
      default:               stat.rd_bit = 1'b0;
    endcase
    stat.sel   = sel_r;
    stat.irq   = pend_nxt & imask_nxt;
    stat.pulse = (cmd.req == edc_pkg::REQ_SAMPLE) & trig & emask_r;
  end

  // Lane state advances on every accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imask_r <= 1'b0;
      emask_r <= 1'b0;
      ren_r   <= 1'b0;
      fen_r   <= 1'b0;
      pend_r  <= 1'b0;
      last_r  <= 1'b0;
      sel_r   <= '0;
    end else if (cmd.valid) begin
      imask_r <= imask_nxt;
      emask_r <= emask_nxt;
      ren_r   <= ren_nxt;
      fen_r   <= fen_nxt;
      pend_r  <= pend_nxt;
      last_r  <= last_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

// ===== rtl/edc_merge.sv =====
// Merge stage: gathers the lane reports into one result and holds the output register.
`timescale 1ns / 1ps

module edc_merge (
  input  logic                    clk,
  input  logic                    rst_n,
  input  edc_pkg::edc_cmd_t       cmd,
  input  edc_pkg::edc_lane_stat_t lane_stat [edc_pkg::MAX_LINES],
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [47:0]             out_tdata
);

  logic [edc_pkg::DATA_W-1:0] bit_word;
  logic [edc_pkg::DATA_W-1:0] sel_word [edc_pkg::SEL_WORDS];
  logic [edc_pkg::DATA_W-1:0] irq_word;
  logic [edc_pkg::DATA_W-1:0] pulse_word;
  logic [edc_pkg::DATA_W-1:0] rd_word;
  logic                       out_valid_r;
  logic [47:0]                out_data_r;

  // Collect per-lane bits into words.
  always_comb begin
    for (int w = 0; w < edc_pkg::SEL_WORDS; w++) begin
      sel_word[w] = '0;
    end
    for (int l = 0; l < edc_pkg::MAX_LINES; l++) begin
      bit_word[l]   = lane_stat[l].rd_bit;
      irq_word[l]   = lane_stat[l].irq;
      pulse_word[l] = lane_stat[l].pulse;
      sel_word[l / 4][4 * (l % 4) +: edc_pkg::NIB_W] = lane_stat[l].sel;
    end
  end

  // Register read data; only reads return a value.
  always_comb begin
    rd_word = '0;
    if (cmd.req == edc_pkg::REQ_READ) begin
      case (cmd.idx)
        edc_pkg::REG_INT_MASK,
        edc_pkg::REG_EVT_MASK,
        edc_pkg::REG_RISE_EN,
        edc_pkg::REG_FALL_EN,
        edc_pkg::REG_PENDING:  rd_word = bit_word;
        edc_pkg::REG_SEL0:     rd_word = sel_word[0];
        edc_pkg::REG_SEL1:     rd_word = sel_word[1];
        edc_pkg::REG_SEL2:     rd_word = sel_word[2];
        edc_pkg::REG_SEL3:     rd_word = sel_word[3];
        default:               rd_word = '0;
      endcase
    end
  end

  // Output register: loads on each accepted transfer, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      out_data_r <= {pulse_word, irq_word, rd_word};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the external interrupt edge controller.
`timescale 1ns / 1ps

module tb_top;

  localparam int LINES = 16;
  localparam int PORTS = 4;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_FIRST = 150;
  localparam int CALM_LAST = 250;
  localparam int IDLE_PERCENT = 37;
  localparam int DRAIN_CYCLES = 8;

  // Field widths taken from the package.
  localparam int DATA_W    = edc_pkg::DATA_W;
  localparam int PIN_W     = edc_pkg::PIN_W;
  localparam int NIB_W     = edc_pkg::NIB_W;
  localparam int MAX_LINES = edc_pkg::MAX_LINES;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [3:0] REG_FIRST_UNKNOWN = 4'd9;
  localparam logic [3:0] REG_LAST_UNKNOWN = 4'd15;

  // One result transfer, fields as they sit in out_tdata.
  typedef struct packed {
    logic [DATA_W-1:0] pulse;
    logic [DATA_W-1:0] irq;
    logic [DATA_W-1:0] rd;
  } result_t;

  // One stimulus row: request fields and an optional typed-in result.
  typedef struct packed {
    logic [1:0]        req;
    logic [3:0]        idx;
    logic [DATA_W-1:0] wdata;
    logic [PIN_W-1:0]  pins;
    logic              typed;
    result_t           exp;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [15:0] write_data, [79:16] pin_levels
  logic [79:0] in_tdata;
  // [1:0] req_type, [5:2] reg_index
  logic [5:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // [15:0] read_data, [31:16] irq_lines, [47:32] event_pulse
  logic [47:0] out_tdata;

  // Shadow copy of the controller registers.
  logic [DATA_W-1:0] shadow_int_mask;
  logic [DATA_W-1:0] shadow_evt_mask;
  logic [DATA_W-1:0] shadow_rise;
  logic [DATA_W-1:0] shadow_fall;
  logic [DATA_W-1:0] shadow_pending;
  logic [DATA_W-1:0] shadow_level;
  logic [NIB_W-1:0]  shadow_sel [MAX_LINES];

  result_t   expected_results[$];
  stim_row_t directed_plan[$];
  int        mismatch_count;
  bit        calm;

  external_interrupt_edge_controller #(
    .LINES(LINES),
    .PORTS(PORTS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #200000;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [DATA_W-1:0] line_mask();
    return DATA_W'((17'd1 << LINES) - 17'd1);
  endfunction

  // Computes the result of one request and advances the shadow registers.
  function automatic result_t predict_controller(input logic [1:0] req,
                                                 input logic [3:0] idx,
                                                 input logic [DATA_W-1:0] wdata,
                                                 input logic [PIN_W-1:0] pins);
    result_t res;
    logic [DATA_W-1:0] lm;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] trig;
    int port;
    int word;
    lm = line_mask();
    res = '0;
    if (req == edc_pkg::REQ_SAMPLE) begin
      cur = '0;
      for (int line = 0; line < LINES; line++) begin
        port = int'(shadow_sel[line]);
        if (port < PORTS) cur[line] = pins[16 * port + line];
      end
      trig = ((cur & ~shadow_level & shadow_rise) |
              (~cur & shadow_level & shadow_fall)) & lm;
      shadow_pending = (shadow_pending | trig) & lm;
      res.pulse = trig & shadow_evt_mask;
      shadow_level = cur & lm;
    end else if (req == edc_pkg::REQ_READ) begin
      case (idx)
        edc_pkg::REG_INT_MASK: res.rd = shadow_int_mask;
        edc_pkg::REG_EVT_MASK: res.rd = shadow_evt_mask;
        edc_pkg::REG_RISE_EN:  res.rd = shadow_rise;
        edc_pkg::REG_FALL_EN:  res.rd = shadow_fall;
        edc_pkg::REG_PENDING:  res.rd = shadow_pending;
        edc_pkg::REG_SEL0, edc_pkg::REG_SEL1,
        edc_pkg::REG_SEL2, edc_pkg::REG_SEL3: begin
          word = int'(idx - edc_pkg::REG_SEL0);
          for (int i = 0; i < 4; i++) begin
            if (word * 4 + i < LINES) res.rd[4 * i +: 4] = shadow_sel[word * 4 + i];
          end
        end
        default: res.rd = '0;
      endcase
    end else if (req == edc_pkg::REQ_WRITE) begin
      case (idx)
        edc_pkg::REG_INT_MASK: shadow_int_mask = wdata & lm;
        edc_pkg::REG_EVT_MASK: shadow_evt_mask = wdata & lm;
        edc_pkg::REG_RISE_EN:  shadow_rise = wdata & lm;
        edc_pkg::REG_FALL_EN:  shadow_fall = wdata & lm;
        edc_pkg::REG_PENDING:  shadow_pending = shadow_pending & ~wdata & lm;
        edc_pkg::REG_SEL0, edc_pkg::REG_SEL1,
        edc_pkg::REG_SEL2, edc_pkg::REG_SEL3: begin
          word = int'(idx - edc_pkg::REG_SEL0);
          for (int i = 0; i < 4; i++) begin
            if (word * 4 + i < LINES) shadow_sel[word * 4 + i] = wdata[4 * i +: 4];
          end
        end
        default: ;
      endcase
    end
    res.irq = shadow_pending & shadow_int_mask & lm;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, field, want, got);
    mismatch_count++;
  endtask

  // Drives one request and records its expected result once the transfer happens.
  task automatic send_transfer(input stim_row_t item);
    result_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {item.idx, item.req};
    in_tdata <= {item.pins, item.wdata};
    do @(posedge clk); while (!in_tready);
    predicted = predict_controller(item.req, item.idx, item.wdata, item.pins);
    expected_results.push_back(item.typed ? item.exp : predicted);
  endtask

  // Source-select word with a bias toward ports that exist.
  function automatic logic [DATA_W-1:0] random_select_word();
    logic [DATA_W-1:0] w;
    for (int i = 0; i < 4; i++) begin
      w[4 * i +: 4] = ($urandom_range(99) < 70) ? NIB_W'($urandom_range(PORTS - 1))
                                                : NIB_W'($urandom_range(15));
    end
    return w;
  endfunction

  // Random request: mostly samples and valid register accesses, some noise.
  function automatic stim_row_t random_row();
    stim_row_t row;
    int pick;
    row = '0;
    row.wdata = DATA_W'($urandom);
    row.pins = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 50) begin
      row.req = edc_pkg::REQ_SAMPLE;
      row.idx = 4'($urandom_range(15));
    end else if (pick < 95) begin
      row.req = (pick < 70) ? edc_pkg::REQ_READ : edc_pkg::REQ_WRITE;
      row.idx = ($urandom_range(99) < 90) ? 4'($urandom_range(8))
                                          : 4'($urandom_range(REG_LAST_UNKNOWN,
                                                              REG_FIRST_UNKNOWN));
      if (row.idx >= edc_pkg::REG_SEL0 && row.idx <= edc_pkg::REG_SEL3 &&
          $urandom_range(1))
        row.wdata = random_select_word();
    end else begin
      row.req = REQ_UNUSED;
      row.idx = 4'($urandom_range(15));
    end
    return row;
  endfunction

  // Result side: random stalls and field-by-field comparison.
  initial begin
    result_t got;
    result_t want;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $display("[%0t] result transfer with nothing expected: %h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.rd !== want.rd) report_mismatch("read_data", want.rd, got.rd);
          if (got.irq !== want.irq) report_mismatch("irq_lines", want.irq, got.irq);
          if (got.pulse !== want.pulse) report_mismatch("event_pulse", want.pulse, got.pulse);
        end
      end
      out_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Stimulus: reset, directed table, random part, drain.
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    mismatch_count = 0;
    calm = 1'b0;
    shadow_int_mask = '0;
    shadow_evt_mask = '0;
    shadow_rise = '0;
    shadow_fall = '0;
    shadow_pending = '0;
    shadow_level = '0;
    foreach (shadow_sel[i]) shadow_sel[i] = '0;

    // Directed rows; typed results only where they are obvious.
    directed_plan.push_back('{edc_pkg::REQ_READ, edc_pkg::REG_INT_MASK, 16'h0, 64'h0,
                              1'b1, '{16'h0, 16'h0, 16'h0}});
    directed_plan.push_back('{edc_pkg::REQ_READ, edc_pkg::REG_SEL0, 16'h0, 64'h0,
                              1'b1, '{16'h0, 16'h0, 16'h0}});
    // All pins high with no edge enabled: nothing triggers.
    directed_plan.push_back('{edc_pkg::REQ_SAMPLE, edc_pkg::REG_INT_MASK, 16'h0,
                              {64{1'b1}}, 1'b1, '{16'h0, 16'h0, 16'h0}});
    directed_plan.push_back('{edc_pkg::REQ_READ, REG_LAST_UNKNOWN, 16'h0, 64'h0,
                              1'b1, '{16'h0, 16'h0, 16'h0}});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_INT_MASK, 16'hffff, 64'h0,
                              1'b1, '{16'h0, 16'h0, 16'h0}});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_EVT_MASK, 16'hffff, 64'h0,
                              1'b1, '{16'h0, 16'h0, 16'h0}});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_RISE_EN, 16'hffff, 64'h0,
                              1'b1, '{16'h0, 16'h0, 16'h0}});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_FALL_EN, 16'hffff, 64'h0,
                              1'b1, '{16'h0, 16'h0, 16'h0}});
    // Every line falls at once.
    directed_plan.push_back('{edc_pkg::REQ_SAMPLE, edc_pkg::REG_INT_MASK, 16'h0, 64'h0,
                              1'b1, '{16'hffff, 16'hffff, 16'h0}});
    directed_plan.push_back('{edc_pkg::REQ_READ, edc_pkg::REG_PENDING, 16'h0, 64'h0,
                              1'b1, '{16'h0, 16'hffff, 16'hffff}});
    // Write one to clear: half, then the rest.
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_PENDING, 16'h00ff, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_PENDING, 16'hffff, 64'h0,
                              1'b1, '{16'h0, 16'h0, 16'h0}});
    // Source selects, including ports that do not exist.
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_SEL0, 16'h3210, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_SEL1, 16'hf4a5, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_SEL2, 16'h1111, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_SEL3, 16'hffff, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_READ, edc_pkg::REG_SEL1, 16'h0, 64'h0,
                              1'b1, '{16'h0, 16'h0, 16'hf4a5}});
    directed_plan.push_back('{edc_pkg::REQ_SAMPLE, edc_pkg::REG_INT_MASK, 16'h0,
                              64'haaaa_5555_ffff_0000, 1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_SAMPLE, edc_pkg::REG_INT_MASK, 16'h0,
                              {64{1'b1}}, 1'b0, '0});
    // Unused request type and unknown register.
    directed_plan.push_back('{REQ_UNUSED, edc_pkg::REG_PENDING, 16'hffff, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, REG_FIRST_UNKNOWN, 16'hffff, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_READ, REG_FIRST_UNKNOWN, 16'h0, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_SAMPLE, edc_pkg::REG_INT_MASK, 16'h0, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_READ, edc_pkg::REG_SEL3, 16'h0, 64'h0,
                              1'b0, '0});
    directed_plan.push_back('{edc_pkg::REQ_WRITE, edc_pkg::REG_INT_MASK, 16'h0, 64'h0,
                              1'b0, '0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) send_transfer(directed_plan[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      send_transfer(random_row());
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain the remaining results, then watch for strays.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/edc_pkg.sv
rtl/edc_lane.sv
rtl/edc_merge.sv
rtl/external_interrupt_edge_controller.sv
tb/tb_top.sv
